@@ design/mstt_pkg.sv @@
// Shared types and codes for the multi-slot timer table.
`timescale 1ns / 1ps
`default_nettype none
package mstt_pkg;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_TICK       = 2'd2,
		OP_GET        = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_REGISTERED = 3'd0,
		KIND_FULL       = 3'd1,
		KIND_REMOVED    = 3'd2,
		KIND_NOT_FOUND  = 3'd3,
		KIND_FOUND      = 3'd4,
		KIND_FIRED      = 3'd5,
		KIND_TICK_DONE  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Control from the sequencer to the slot update unit.
	typedef struct packed {
		op_t  op;
		logic done;
	} slot_ctl_t;

	// Status from the slot update unit back to the sequencer.
	typedef struct packed {
		logic hit;
		logic fire;
	} slot_sts_t;

	localparam int unsigned TIME_W = 32;

endpackage
`default_nettype wire

@@ design/mstt_cell.sv @@
// One timer slot of the rotating ring; loads its neighbor's record on every shift.
`timescale 1ns / 1ps
`default_nettype none
module mstt_cell #(
	parameter int unsigned KEY_W = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             shift_en,
	input  wire logic                             d_valid,
	input  wire logic [KEY_W-1:0]                 d_key,
	input  wire logic [mstt_pkg::TIME_W-1:0]      d_period,
	input  wire logic [mstt_pkg::TIME_W-1:0]      d_elapsed,
	input  wire logic                             d_periodic,
	output logic                                  q_valid,
	output logic [KEY_W-1:0]                      q_key,
	output logic [mstt_pkg::TIME_W-1:0]           q_period,
	output logic [mstt_pkg::TIME_W-1:0]           q_elapsed,
	output logic                                  q_periodic
);
	import mstt_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] elapsed_q;
	logic             periodic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q      <= d_key;
			period_q   <= d_period;
			elapsed_q  <= d_elapsed;
			periodic_q <= d_periodic;
		end
	end

	assign q_valid    = valid_q;
	assign q_key      = key_q;
	assign q_period   = period_q;
	assign q_elapsed  = elapsed_q;
	assign q_periodic = periodic_q;

endmodule
`default_nettype wire

@@ design/mstt_slot_ctl.sv @@
// Update unit at the head of the ring: applies the current operation to one slot.
`timescale 1ns / 1ps
`default_nettype none
module mstt_slot_ctl #(
	parameter int unsigned KEY_W = 8
) (
	input  mstt_pkg::slot_ctl_t                   ctl,
	input  wire logic [KEY_W-1:0]                 id,
	input  wire logic [mstt_pkg::TIME_W-1:0]      new_period,
	input  wire logic                             new_periodic,
	input  wire logic [mstt_pkg::TIME_W-1:0]      delta,
	input  wire logic                             c_valid,
	input  wire logic [KEY_W-1:0]                 c_key,
	input  wire logic [mstt_pkg::TIME_W-1:0]      c_period,
	input  wire logic [mstt_pkg::TIME_W-1:0]      c_elapsed,
	input  wire logic                             c_periodic,
	output logic                                  n_valid,
	output logic [KEY_W-1:0]                      n_key,
	output logic [mstt_pkg::TIME_W-1:0]           n_period,
	output logic [mstt_pkg::TIME_W-1:0]           n_elapsed,
	output logic                                  n_periodic,
	output mstt_pkg::slot_sts_t                   sts
);
	import mstt_pkg::*;

	logic              match;
	logic [TIME_W:0]   sum;
	logic [TIME_W+1:0] diff;
	logic              sat;
	logic              reached;
	logic [TIME_W-1:0] esat;
	logic [TIME_W-1:0] rem;

	assign match = c_valid && (c_key == id);

	// The remainder after firing is computed beside the saturating sum, not after it.
	assign sum     = {1'b0, c_elapsed} + {1'b0, delta};
	assign diff    = {2'b00, c_elapsed} + {2'b00, delta} - {2'b00, c_period};
	assign sat     = sum[TIME_W];
	assign esat    = sat ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	assign reached = sat || !diff[TIME_W+1];
	assign rem     = sat ? ~c_period : diff[TIME_W-1:0];

	always_comb begin
		n_valid    = c_valid;
		n_key      = c_key;
		n_period   = c_period;
		n_elapsed  = c_elapsed;
		n_periodic = c_periodic;
		sts        = '0;
		case (ctl.op)
			OP_REGISTER: begin
				// The lowest slot that is free once old copies of the id are gone.
				if (!ctl.done && (!c_valid || match)) begin
					n_valid    = 1'b1;
					n_key      = id;
					n_period   = new_period;
					n_elapsed  = '0;
					n_periodic = new_periodic;
					sts.hit    = 1'b1;
				end else if (match) begin
					n_valid    = 1'b0;
					n_key      = '0;
					n_period   = '0;
					n_elapsed  = '0;
					n_periodic = 1'b0;
				end
			end
			OP_UNREGISTER: begin
				if (!ctl.done && match) begin
					n_valid    = 1'b0;
					n_key      = '0;
					n_period   = '0;
					n_elapsed  = '0;
					n_periodic = 1'b0;
					sts.hit    = 1'b1;
				end
			end
			OP_GET: begin
				sts.hit = !ctl.done && match;
			end
			OP_TICK: begin
				if (c_valid) begin
					n_elapsed = esat;
					if (reached) begin
						sts.fire = 1'b1;
						if (c_periodic) begin
							n_elapsed = rem;
						end else begin
							n_valid    = 1'b0;
							n_key      = '0;
							n_period   = '0;
							n_elapsed  = '0;
							n_periodic = 1'b0;
						end
					end
				end
			end
			default: begin
				sts = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/multi_slot_timer_table_core.sv @@
// Top level of the multi-slot timer table: slot ring, sequencer and result register.
//
// Usage: one command enters on the input channel (op, timer_id, period, repeat_req,
// delta) when in_valid is high and in_stall is low. Results leave on the output
// channel (kind, result_id, result_period, result_repeat, last) on each transfer
// with out_valid high and out_stall low; last marks the final result of a command.
// The slots sit in a ring of NUM_SLOTS cells that rotates one place per cycle during
// a walk past a single update unit, so every command visits the slots in order.
// A command walks the whole ring before the next one is accepted. Register,
// unregister and get raise out_valid with one result after the walk; a tick
// gives its fired events as the slots pass the head and the tick-done result
// after the walk.
// While the output register holds an event that is stalled, the ring stops at the
// next slot that fires, and resumes once the event is taken. The next command is
// accepted as soon as the final result sits in the output register.
// Reset clears all slot valid bits at once; the table is empty and ready at once.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_timer_table_core #(
	parameter int unsigned NUM_SLOTS = 32,
	parameter int unsigned ID_BITS   = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  mstt_pkg::op_t                op,
	input  wire logic [7:0]              timer_id,
	input  wire logic [31:0]             period,
	input  wire logic                    repeat_req,
	input  wire logic [31:0]             delta,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output mstt_pkg::kind_t              kind,
	output logic [7:0]                   result_id,
	output logic [31:0]                  result_period,
	output logic                         result_repeat,
	output logic                         last
);
	import mstt_pkg::*;

	localparam int unsigned CW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [ID_BITS-1:0] id_q;
	logic [TIME_W-1:0] period_q;
	logic              rep_q;
	logic [TIME_W-1:0] delta_q;
	logic              done_q;
	logic [TIME_W-1:0] fnd_period_q;
	logic              fnd_rep_q;
	logic [CW-1:0]     cnt_q;

	logic              ov_q;
	kind_t             kind_q;
	logic [7:0]        rid_q;
	logic [TIME_W-1:0] rper_q;
	logic              rrep_q;
	logic              last_q;

	logic [15:0]        id_wide;
	logic [ID_BITS-1:0] id_in;
	logic [15:0]        key_wide;

	logic               v_a   [NUM_SLOTS];
	logic [ID_BITS-1:0] key_a [NUM_SLOTS];
	logic [TIME_W-1:0]  per_a [NUM_SLOTS];
	logic [TIME_W-1:0]  el_a  [NUM_SLOTS];
	logic               rp_a  [NUM_SLOTS];

	logic               h_valid;
	logic [ID_BITS-1:0] h_key;
	logic [TIME_W-1:0]  h_period;
	logic [TIME_W-1:0]  h_elapsed;
	logic               h_periodic;

	slot_ctl_t ctl;
	slot_sts_t sts;

	logic in_xfer;
	logic out_free;
	logic step;
	logic load_evt;
	logic load_fin;
	logic last_step;
	kind_t fin_kind;

	assign id_wide  = {8'h00, timer_id};
	assign id_in    = id_wide[ID_BITS-1:0];
	// The key of a fired slot is taken before the update unit clears a one-shot slot.
	assign key_wide = 16'(key_a[0]);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !ov_q || !out_stall;
	assign last_step = (cnt_q == CW'(NUM_SLOTS - 1));

	assign ctl.op   = op_q;
	assign ctl.done = done_q;

	// A slot that fires waits at the head until the output register can take it.
	assign step     = (state_q == ST_SCAN) && (!sts.fire || out_free);
	assign load_evt = step && sts.fire;
	assign load_fin = (state_q == ST_DONE) && out_free;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_ring
			if (gi == NUM_SLOTS - 1) begin : g_tail
				mstt_cell #(.KEY_W(ID_BITS)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift_en   (step),
					.d_valid    (h_valid),
					.d_key      (h_key),
					.d_period   (h_period),
					.d_elapsed  (h_elapsed),
					.d_periodic (h_periodic),
					.q_valid    (v_a[gi]),
					.q_key      (key_a[gi]),
					.q_period   (per_a[gi]),
					.q_elapsed  (el_a[gi]),
					.q_periodic (rp_a[gi])
				);
			end else begin : g_body
				mstt_cell #(.KEY_W(ID_BITS)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift_en   (step),
					.d_valid    (v_a[gi+1]),
					.d_key      (key_a[gi+1]),
					.d_period   (per_a[gi+1]),
					.d_elapsed  (el_a[gi+1]),
					.d_periodic (rp_a[gi+1]),
					.q_valid    (v_a[gi]),
					.q_key      (key_a[gi]),
					.q_period   (per_a[gi]),
					.q_elapsed  (el_a[gi]),
					.q_periodic (rp_a[gi])
				);
			end
		end
	endgenerate

	mstt_slot_ctl #(.KEY_W(ID_BITS)) u_slot_ctl (
		.ctl          (ctl),
		.id           (id_q),
		.new_period   (period_q),
		.new_periodic (rep_q),
		.delta        (delta_q),
		.c_valid      (v_a[0]),
		.c_key        (key_a[0]),
		.c_period     (per_a[0]),
		.c_elapsed    (el_a[0]),
		.c_periodic   (rp_a[0]),
		.n_valid      (h_valid),
		.n_key        (h_key),
		.n_period     (h_period),
		.n_elapsed    (h_elapsed),
		.n_periodic   (h_periodic),
		.sts          (sts)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (step && last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_REGISTER:   fin_kind = done_q ? KIND_REGISTERED : KIND_FULL;
			OP_UNREGISTER: fin_kind = done_q ? KIND_REMOVED : KIND_NOT_FOUND;
			OP_GET:        fin_kind = done_q ? KIND_FOUND : KIND_NOT_FOUND;
			OP_TICK:       fin_kind = KIND_TICK_DONE;
			default:       fin_kind = KIND_TICK_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				cnt_q  <= '0;
				done_q <= 1'b0;
			end else if (step) begin
				cnt_q <= last_step ? '0 : cnt_q + CW'(1);
				if (sts.hit) begin
					done_q <= 1'b1;
				end
			end
			if (load_evt || load_fin) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Zero-extends a stored key to 16 bits and keeps the low byte for the port.
	function automatic logic [7:0] id_wide_q_low(input logic [ID_BITS-1:0] k);
		logic [15:0] w;
		w = 16'(k);
		return w[7:0];
	endfunction

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= op;
			id_q     <= id_in;
			period_q <= period;
			rep_q    <= repeat_req;
			delta_q  <= delta;
		end
		if (step && sts.hit) begin
			fnd_period_q <= per_a[0];
			fnd_rep_q    <= rp_a[0];
		end
		if (load_evt) begin
			kind_q <= KIND_FIRED;
			rid_q  <= key_wide[7:0];
			rper_q <= per_a[0];
			rrep_q <= rp_a[0];
			last_q <= 1'b0;
		end else if (load_fin) begin
			kind_q <= fin_kind;
			rid_q  <= (op_q == OP_TICK) ? 8'h00 : id_wide_q_low(id_q);
			rper_q <= (fin_kind == KIND_FOUND) ? fnd_period_q : '0;
			rrep_q <= (fin_kind == KIND_FOUND) ? fnd_rep_q : 1'b0;
			last_q <= 1'b1;
		end
	end

	assign out_valid     = ov_q;
	assign kind          = kind_q;
	assign result_id     = rid_q;
	assign result_period = rper_q;
	assign result_repeat = rrep_q;
	assign last          = last_q;

	a_evt_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (kind_q == KIND_FIRED) |-> !last_q)
		else $error("fired event marked as last result");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_SCAN) && (cnt_q == '0) && !done_q)
		else $error("accepted command did not start a slot walk");

	a_ring_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.fire && !out_free |=> $stable(cnt_q))
		else $error("ring moved while a fired event was blocked");

	a_done_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (cnt_q == '0))
		else $error("final result before the ring came full circle");

	a_fire_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.fire |-> (op_q == OP_TICK))
		else $error("slot fired outside a tick");

endmodule
`default_nettype wire
